[src/randomized_set_table_defines.svh]
// Assertion macros for the randomized set table; empty bodies under synthesis.
`ifndef RANDOMIZED_SET_TABLE_DEFINES_SVH
`define RANDOMIZED_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RSET_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define RSET_ASSERT(label, prop, msg)
`define RSET_ASSERT_IMPL(label, cond, prop, msg)
`endif

`endif

[src/rset_pkg.sv]
// Shared constants, codes and types of the randomized set table.
package rset_pkg;

    localparam int CAPACITY     = 64;
    localparam int DATA_W       = 32;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int COMMAND_W    = 2;
    localparam int RANDOM_W     = 16;
    localparam int STATUS_W     = 3;
    localparam int ITEM_COUNT_W = 7;

    // read-out OR tree
    localparam int GROUP_SIZE   = 8;
    localparam int NUM_GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int TREE_LAT     = 3;

    // modulo unit: bits retired per cycle
    localparam int DIV_STEPS    = 4;
    localparam int DIV_ITERS    = RANDOM_W / DIV_STEPS;
    localparam int DIV_ITER_W   = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

    localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_PICK   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY       = 3'd4;

    typedef struct packed {
        logic              write_tail;  // load first free cell
        logic              write_hit;   // load the matching cell
        logic              clear_last;  // drop the last occupied cell
        logic              sel_last;    // read-out picks last cell, else rd_slot
        logic [SLOT_W-1:0] rd_slot;
    } cell_ctl_t;

endpackage

[src/rset_if.sv]
// Request and response channel interfaces of the randomized set table.
interface rset_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [rset_pkg::COMMAND_W-1:0]       command;
    logic signed [rset_pkg::DATA_W-1:0]   item_value;
    logic [rset_pkg::RANDOM_W-1:0]        random_word;

    modport source (output valid, command, item_value, random_word, input ready);
    modport sink (input valid, command, item_value, random_word, output ready);
endinterface

interface rset_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 success;
    logic [rset_pkg::STATUS_W-1:0]        status;
    logic signed [rset_pkg::DATA_W-1:0]   picked_value;
    logic [rset_pkg::ITEM_COUNT_W-1:0]    item_count;

    modport source (output valid, success, status, picked_value, item_count, input ready);
    modport sink (input valid, success, status, picked_value, item_count, output ready);
endinterface

[src/rset_cell.sv]
// One storage cell: value, occupancy, key match and masked read-out.
module rset_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rset_pkg::SLOT_W-1:0]   cell_index,
    input  rset_pkg::cell_ctl_t           ctl,
    input  logic [rset_pkg::DATA_W-1:0]   key,
    input  logic [rset_pkg::DATA_W-1:0]   wr_data,
    input  logic                          prev_occ,
    input  logic                          next_occ,
    output logic                          occ,
    output logic                          hit,
    output logic [rset_pkg::DATA_W-1:0]   rd_data
);

    logic                          occ_reg;
    logic                          occ_next;
    logic                          hit_reg;
    logic [rset_pkg::DATA_W-1:0]   value_reg;
    logic [rset_pkg::DATA_W-1:0]   rd_reg;
    logic                          is_tail;
    logic                          is_last;
    logic                          load;
    logic                          sel;

    // tail = first free cell, last = last occupied cell; both seen through the neighbors
    assign is_tail = prev_occ && !occ_reg;
    assign is_last = occ_reg && !next_occ;
    assign load    = (ctl.write_tail && is_tail) || (ctl.write_hit && hit_reg);
    assign sel     = ctl.sel_last ? is_last : (cell_index == ctl.rd_slot);

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.write_tail && is_tail)
        begin
            occ_next = 1'b1;
        end
        else if (ctl.clear_last && is_last)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            hit_reg <= occ_reg && (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= wr_data;
        end
        rd_reg <= sel ? value_reg : '0;
    end

    assign occ     = occ_reg;
    assign hit     = hit_reg;
    assign rd_data = rd_reg;

endmodule

[src/rset_tree.sv]
// Two-level registered OR tree that collects the one selected cell value.
module rset_tree (
    input  logic                          clk,
    input  logic [rset_pkg::DATA_W-1:0]   leaf [rset_pkg::CAPACITY],
    output logic [rset_pkg::DATA_W-1:0]   data
);

    logic [rset_pkg::DATA_W-1:0] group_next [rset_pkg::NUM_GROUPS];
    logic [rset_pkg::DATA_W-1:0] group_reg  [rset_pkg::NUM_GROUPS];
    logic [rset_pkg::DATA_W-1:0] data_next;
    logic [rset_pkg::DATA_W-1:0] data_reg;

    always_comb
    begin
        for (int g = 0; g < rset_pkg::NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < rset_pkg::GROUP_SIZE; j++)
            begin
                if (g * rset_pkg::GROUP_SIZE + j < rset_pkg::CAPACITY)
                begin
                    group_next[g] = group_next[g] | leaf[g * rset_pkg::GROUP_SIZE + j];
                end
            end
        end
    end

    always_comb
    begin
        data_next = '0;
        for (int g = 0; g < rset_pkg::NUM_GROUPS; g++)
        begin
            data_next = data_next | group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
        data_reg  <= data_next;
    end

    assign data = data_reg;

endmodule

[src/rset_div.sv]
// Iterative restoring modulo unit, several quotient bits per cycle.
module rset_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rset_pkg::RANDOM_W-1:0]   dividend,
    input  logic [rset_pkg::CNT_W-1:0]      divisor,
    output logic                            done,
    output logic [rset_pkg::CNT_W-1:0]      remainder
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [rset_pkg::DIV_ITER_W-1:0]   iter_reg;
    logic [rset_pkg::RANDOM_W-1:0]     dvd_reg;
    logic [rset_pkg::RANDOM_W-1:0]     dvd_next;
    logic [rset_pkg::CNT_W-1:0]        dsr_reg;
    logic [rset_pkg::CNT_W-1:0]        rem_reg;
    logic [rset_pkg::CNT_W-1:0]        rem_next;
    logic [rset_pkg::CNT_W:0]          trial;
    logic                              last_iter;

    assign last_iter = (iter_reg == rset_pkg::DIV_ITER_W'(rset_pkg::DIV_ITERS - 1));

    // partial remainder stays below the divisor, so one subtract per bit is enough
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        for (int k = 0; k < rset_pkg::DIV_STEPS; k++)
        begin
            trial = {rem_next, dvd_next[rset_pkg::RANDOM_W-1]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            rem_next = trial[rset_pkg::CNT_W-1:0];
            dvd_next = {dvd_next[rset_pkg::RANDOM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + rset_pkg::DIV_ITER_W'(1);
            if (last_iter)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[src/randomized_set_table.sv]
// Randomized set table: one operation at a time; beat accepted only in idle.
// Path from beat accepted to result registered: insert, misses and empty pick
// pass MATCH, DECIDE, DONE; remove adds READ (OR-tree read of the last cell)
// and APPLY; pick adds DIV (16-bit modulo by the count at 4 bits per cycle),
// then READ and APPLY. Next beat is taken in IDLE, after the result is registered.
// Reset clears count and cell occupancy at once; stored values stay undefined.
`include "randomized_set_table_defines.svh"

module randomized_set_table (
    input  logic          clk,
    input  logic          rst_n,
    rset_req_if.sink      req,
    rset_rsp_if.source    rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [rset_pkg::COMMAND_W-1:0]    cmd_reg;
    logic [rset_pkg::DATA_W-1:0]       key_reg;
    logic [rset_pkg::RANDOM_W-1:0]     rnd_reg;
    logic [rset_pkg::CNT_W-1:0]        count_reg;
    logic [rset_pkg::CNT_W-1:0]        count_next;
    logic [rset_pkg::CNT_W-1:0]        count_plus1;
    logic                              sel_last_reg;
    logic [rset_pkg::SLOT_W-1:0]       rd_slot_reg;
    logic [1:0]                        lat_reg;
    logic                              res_success_reg;
    logic [rset_pkg::STATUS_W-1:0]     res_status_reg;
    logic [rset_pkg::DATA_W-1:0]       res_picked_reg;
    logic                              out_valid_reg;
    logic                              out_success_reg;
    logic [rset_pkg::STATUS_W-1:0]     out_status_reg;
    logic [rset_pkg::DATA_W-1:0]       out_picked_reg;
    logic [rset_pkg::ITEM_COUNT_W-1:0] out_count_reg;

    rset_pkg::cell_ctl_t               ctl;
    logic [rset_pkg::DATA_W-1:0]       wr_data;
    logic [rset_pkg::CAPACITY-1:0]     occ_vec;
    logic [rset_pkg::CAPACITY-1:0]     hit_vec;
    logic [rset_pkg::DATA_W-1:0]       leaf [rset_pkg::CAPACITY];
    logic [rset_pkg::DATA_W-1:0]       tree_data;
    logic                              any_hit;
    logic                              full;
    logic                              div_start;
    logic                              div_done;
    logic [rset_pkg::CNT_W-1:0]        div_rem;
    logic                              out_free;
    logic                              accept;

    assign accept      = req.valid && req.ready;
    assign any_hit     = |hit_vec;
    assign full        = (count_reg == rset_pkg::CNT_W'(rset_pkg::CAPACITY));
    assign out_free    = !out_valid_reg || rsp.ready;
    assign div_start   = (state_reg == S_MATCH) && (cmd_reg == rset_pkg::CMD_PICK);
    assign count_plus1 = count_reg + rset_pkg::CNT_W'(1);

    always_comb
    begin
        ctl            = '0;
        ctl.sel_last   = sel_last_reg;
        ctl.rd_slot    = rd_slot_reg;
        ctl.write_tail = (state_reg == S_DECIDE) && (cmd_reg == rset_pkg::CMD_INSERT)
                         && !any_hit && !full;
        ctl.write_hit  = (state_reg == S_APPLY) && (cmd_reg == rset_pkg::CMD_REMOVE);
        ctl.clear_last = ctl.write_hit;
    end

    // insert writes the key, remove writes the last value into the freed slot
    assign wr_data = (state_reg == S_APPLY) ? tree_data : key_reg;

    genvar i;
    generate
        for (i = 0; i < rset_pkg::CAPACITY; i++)
        begin : g_cell
            logic prev_occ;
            logic next_occ;
            if (i == 0)
            begin : g_first
                assign prev_occ = 1'b1;
            end
            else
            begin : g_prev
                assign prev_occ = occ_vec[i-1];
            end
            if (i == rset_pkg::CAPACITY - 1)
            begin : g_end
                assign next_occ = 1'b0;
            end
            else
            begin : g_next
                assign next_occ = occ_vec[i+1];
            end

            rset_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (rset_pkg::SLOT_W'(i)),
                .ctl        (ctl),
                .key        (key_reg),
                .wr_data    (wr_data),
                .prev_occ   (prev_occ),
                .next_occ   (next_occ),
                .occ        (occ_vec[i]),
                .hit        (hit_vec[i]),
                .rd_data    (leaf[i])
            );
        end
    endgenerate

    rset_tree u_tree (
        .clk  (clk),
        .leaf (leaf),
        .data (tree_data)
    );

    rset_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (ctl.write_tail)
                begin
                    count_next = count_plus1;
                end
                if ((cmd_reg == rset_pkg::CMD_REMOVE) && any_hit)
                begin
                    state_next = S_READ;
                end
                else if ((cmd_reg == rset_pkg::CMD_PICK) && (count_reg != '0))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (lat_reg == 2'(rset_pkg::TREE_LAT - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_DONE;
                if (ctl.write_hit)
                begin
                    count_next = count_reg - rset_pkg::CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lat_reg       <= '0;
            sel_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_READ)
            begin
                lat_reg <= lat_reg + 2'd1;
            end
            else
            begin
                lat_reg <= '0;
            end
            if (state_reg == S_DECIDE)
            begin
                sel_last_reg <= (cmd_reg == rset_pkg::CMD_REMOVE);
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            key_reg <= req.item_value;
            rnd_reg <= req.random_word;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            rd_slot_reg <= rset_pkg::SLOT_W'(div_rem);
        end
        if (state_reg == S_DECIDE)
        begin
            res_success_reg <= 1'b0;
            res_status_reg  <= rset_pkg::STAT_OK;
            res_picked_reg  <= '0;
            unique case (cmd_reg)
                rset_pkg::CMD_INSERT:
                begin
                    if (any_hit)
                    begin
                        res_status_reg <= rset_pkg::STAT_PRESENT;
                    end
                    else if (full)
                    begin
                        res_status_reg <= rset_pkg::STAT_FULL;
                    end
                    else
                    begin
                        res_success_reg <= 1'b1;
                    end
                end
                rset_pkg::CMD_REMOVE:
                begin
                    if (!any_hit)
                    begin
                        res_status_reg <= rset_pkg::STAT_NOT_PRESENT;
                    end
                end
                rset_pkg::CMD_PICK:
                begin
                    if (count_reg == '0)
                    begin
                        res_status_reg <= rset_pkg::STAT_EMPTY;
                    end
                end
                default:
                begin
                    res_status_reg <= rset_pkg::STAT_OK;
                end
            endcase
        end
        if (state_reg == S_APPLY)
        begin
            res_success_reg <= 1'b1;
            if (cmd_reg == rset_pkg::CMD_PICK)
            begin
                res_picked_reg <= tree_data;
            end
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_success_reg <= res_success_reg;
            out_status_reg  <= res_status_reg;
            out_picked_reg  <= res_picked_reg;
            out_count_reg   <= rset_pkg::ITEM_COUNT_W'(count_reg);
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.success      = out_success_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.picked_value = out_picked_reg;
    assign rsp.item_count   = out_count_reg;

    `RSET_ASSERT(a_occ_count, ($countones(occ_vec) == int'(count_reg)), "occupancy != count")
    `RSET_ASSERT(a_occ_dense, (((occ_vec >> 1) & ~occ_vec) == '0), "occupied cells not dense")
    `RSET_ASSERT(a_single_hit, $onehot0(hit_vec), "value stored in more than one cell")
    `RSET_ASSERT_IMPL(a_insert_grows, ctl.write_tail, (count_reg == $past(count_plus1)), "no grow")

endmodule
